// File: hdl/iabe_pkg.sv
// types and constants shared by the immediate-format execute unit
// no dependencies; imported by iabe_exec, immediate_alu_branch_execute_top and tb
`default_nettype none

package iabe_pkg;

  localparam int unsigned ModeW = 5;
  localparam int unsigned DataW = 32;
  localparam int unsigned ImmW  = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_ADDI   = 5'd0,
    MODE_ADDIU  = 5'd1,
    MODE_ANDI   = 5'd2,
    MODE_ORI    = 5'd3,
    MODE_XORI   = 5'd4,
    MODE_SLTI   = 5'd5,
    MODE_SLTIU  = 5'd6,
    MODE_LW     = 5'd7,
    MODE_LB     = 5'd8,
    MODE_LBU    = 5'd9,
    MODE_SW     = 5'd10,
    MODE_SB     = 5'd11,
    MODE_BEQ    = 5'd12,
    MODE_BNE    = 5'd13,
    MODE_BGEZ   = 5'd14,
    MODE_BGTZ   = 5'd15,
    MODE_BLEZ   = 5'd16,
    MODE_BLTZ   = 5'd17,
    MODE_BGEZAL = 5'd18,
    MODE_BLTZAL = 5'd19
  } mode_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] rs_value;
    logic [DataW-1:0] rt_value;
    logic [ImmW-1:0]  immediate;
    logic [DataW-1:0] load_data;
  } op_t;

  typedef struct packed {
    logic [DataW-1:0] reg_result;
    logic             reg_write;
    logic             overflow;
    logic [DataW-1:0] mem_addr;
    logic             mem_read;
    logic             mem_write;
    logic             mem_is_byte;
    logic [DataW-1:0] store_data;
    logic             branch_taken;
    logic             link_request;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/immediate_alu_branch_execute_top.sv
// top level of the immediate-format execute unit: operand register, execute logic,
// result register; depends on iabe_pkg and iabe_exec
//
// usage:
//   input channel in_valid/in_ready carries one instruction per transaction:
//   mode, rs_value, rt_value, immediate and load_data
//   result channel out_valid/out_ready carries one result per transaction:
//   register result and write enable, overflow, memory address and controls,
//   store data, branch condition and link request
//   every instruction gives exactly one result, in order; no state is kept
//   between instructions
//   path to result valid: operand register, then the result register behind the
//   execute logic
//   throughput: one per cycle while out_ready is high, via the two-entry pipeline
//   reset: rst_n low empties both registers; out_valid drops and in_ready rises
//   stall: when out_ready is low the result holds, the operand register still
//   takes one more transaction, then in_ready drops until the result is taken
`default_nettype none

module immediate_alu_branch_execute_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [4:0]  in_mode,
  input  wire  [31:0] in_rs_value,
  input  wire  [31:0] in_rt_value,
  input  wire  [15:0] in_immediate,
  input  wire  [31:0] in_load_data,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_reg_result,
  output logic        out_reg_write,
  output logic        out_overflow,
  output logic [31:0] out_mem_addr,
  output logic        out_mem_read,
  output logic        out_mem_write,
  output logic        out_mem_is_byte,
  output logic [31:0] out_store_data,
  output logic        out_branch_taken,
  output logic        out_link_request
);
  import iabe_pkg::*;

  op_t  op_r;
  logic op_valid_r;
  res_t res_r;
  logic res_valid_r;
  res_t res_nxt;
  logic res_load;
  logic op_load;

  assign res_load = op_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !op_valid_r || res_load;
  assign op_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else if (in_ready) begin
      op_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      op_r.mode      <= in_mode;
      op_r.rs_value  <= in_rs_value;
      op_r.rt_value  <= in_rt_value;
      op_r.immediate <= in_immediate;
      op_r.load_data <= in_load_data;
    end
  end

  iabe_exec u_exec (
    .op  (op_r),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_reg_result   = res_r.reg_result;
  assign out_reg_write    = res_r.reg_write;
  assign out_overflow     = res_r.overflow;
  assign out_mem_addr     = res_r.mem_addr;
  assign out_mem_read     = res_r.mem_read;
  assign out_mem_write    = res_r.mem_write;
  assign out_mem_is_byte  = res_r.mem_is_byte;
  assign out_store_data   = res_r.store_data;
  assign out_branch_taken = res_r.branch_taken;
  assign out_link_request = res_r.link_request;

  // accepted transaction always lands in the operand register
  a_op_fill: assert property (@(posedge clk) disable iff (!rst_n)
    op_load |=> op_valid_r)
    else $error("accepted transaction lost");

  // waiting operand keeps its payload while the result register is blocked
  a_op_hold: assert property (@(posedge clk) disable iff (!rst_n)
    op_valid_r && !res_load |=> op_valid_r && $stable(op_r))
    else $error("waiting operand changed");

  // overflow suppresses the register write and clears the result
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.overflow |-> !res_r.reg_write && res_r.reg_result == '0)
    else $error("overflow with register write");

  // a result is never both a load and a store
  a_mem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !(res_r.mem_read && res_r.mem_write))
    else $error("load and store at once");

  // an unwritten destination carries a zero result
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && !res_r.reg_write |-> res_r.reg_result == '0)
    else $error("nonzero result without write");

endmodule

`default_nettype wire

// File: hdl/iabe_exec.sv
// combinational execute logic for one immediate-format instruction
// depends on iabe_pkg for the operand and result structs and the mode codes
`default_nettype none

module iabe_exec (
  input  iabe_pkg::op_t  op,
  output iabe_pkg::res_t res
);
  import iabe_pkg::*;

  logic [DataW-1:0] simm;
  logic [DataW-1:0] zimm;
  logic [DataW-1:0] sum;
  logic             add_ovf;
  logic             neg;
  logic             rs_zero;

  assign simm    = {{(DataW-ImmW){op.immediate[ImmW-1]}}, op.immediate};
  assign zimm    = {{(DataW-ImmW){1'b0}}, op.immediate};
  assign sum     = op.rs_value + simm;
  assign add_ovf = (op.rs_value[DataW-1] == simm[DataW-1]) &&
                   (sum[DataW-1] != op.rs_value[DataW-1]);
  assign neg     = op.rs_value[DataW-1];
  assign rs_zero = (op.rs_value == '0);

  always_comb begin
    res = '0;
    unique case (mode_t'(op.mode))
      MODE_ADDI: begin
        if (add_ovf) begin
          res.overflow = 1'b1;
        end else begin
          res.reg_result = sum;
          res.reg_write  = 1'b1;
        end
      end
      MODE_ADDIU: begin
        res.reg_result = sum;
        res.reg_write  = 1'b1;
      end
      MODE_ANDI: begin
        res.reg_result = op.rs_value & zimm;
        res.reg_write  = 1'b1;
      end
      MODE_ORI: begin
        res.reg_result = op.rs_value | zimm;
        res.reg_write  = 1'b1;
      end
      MODE_XORI: begin
        res.reg_result = op.rs_value ^ zimm;
        res.reg_write  = 1'b1;
      end
      MODE_SLTI: begin
        res.reg_result = {{(DataW-1){1'b0}}, ($signed(op.rs_value) < $signed(simm))};
        res.reg_write  = 1'b1;
      end
      MODE_SLTIU: begin
        res.reg_result = {{(DataW-1){1'b0}}, (op.rs_value < simm)};
        res.reg_write  = 1'b1;
      end
      MODE_LW: begin
        res.reg_result = op.load_data;
        res.reg_write  = 1'b1;
        res.mem_addr   = sum;
        res.mem_read   = 1'b1;
      end
      MODE_LB: begin
        res.reg_result  = {{(DataW-8){op.load_data[7]}}, op.load_data[7:0]};
        res.reg_write   = 1'b1;
        res.mem_addr    = sum;
        res.mem_read    = 1'b1;
        res.mem_is_byte = 1'b1;
      end
      MODE_LBU: begin
        res.reg_result  = {{(DataW-8){1'b0}}, op.load_data[7:0]};
        res.reg_write   = 1'b1;
        res.mem_addr    = sum;
        res.mem_read    = 1'b1;
        res.mem_is_byte = 1'b1;
      end
      MODE_SW: begin
        res.mem_addr   = sum;
        res.mem_write  = 1'b1;
        res.store_data = op.rt_value;
      end
      MODE_SB: begin
        res.mem_addr    = sum;
        res.mem_write   = 1'b1;
        res.mem_is_byte = 1'b1;
        res.store_data  = {{(DataW-8){1'b0}}, op.rt_value[7:0]};
      end
      MODE_BEQ:    res.branch_taken = (op.rs_value == op.rt_value);
      MODE_BNE:    res.branch_taken = (op.rs_value != op.rt_value);
      MODE_BGEZ:   res.branch_taken = !neg;
      MODE_BGTZ:   res.branch_taken = !neg && !rs_zero;
      MODE_BLEZ:   res.branch_taken = neg || rs_zero;
      MODE_BLTZ:   res.branch_taken = neg;
      MODE_BGEZAL: begin
        res.branch_taken = !neg;
        res.link_request = 1'b1;
      end
      MODE_BLTZAL: begin
        res.branch_taken = neg;
        res.link_request = 1'b1;
      end
      default: res = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for immediate_alu_branch_execute_top: directed and random instructions,
// results checked against an in-bench execute model; needs iabe_pkg and the rtl only
`default_nettype none

module tb;
  import iabe_pkg::*;

  localparam logic [ModeW-1:0] MODE_UNUSED_FIRST = 5'd20;
  localparam logic [ModeW-1:0] MODE_UNUSED_LAST  = 5'd31;
  localparam int unsigned      RANDOM_OPS        = 700;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        out_ready = 1'b0;
  op_t         cur_op = '0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] out_reg_result;
  logic        out_reg_write;
  logic        out_overflow;
  logic [31:0] out_mem_addr;
  logic        out_mem_read;
  logic        out_mem_write;
  logic        out_mem_is_byte;
  logic [31:0] out_store_data;
  logic        out_branch_taken;
  logic        out_link_request;

  op_t         pending_ops[$];
  res_t        exec_expected[$];
  logic        in_taken = 1'b0;
  int unsigned total_ops = 0;
  int unsigned issued = 0;
  int unsigned accepted = 0;
  int unsigned fails = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  immediate_alu_branch_execute_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (cur_op.mode),
    .in_rs_value      (cur_op.rs_value),
    .in_rt_value      (cur_op.rt_value),
    .in_immediate     (cur_op.immediate),
    .in_load_data     (cur_op.load_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reg_result   (out_reg_result),
    .out_reg_write    (out_reg_write),
    .out_overflow     (out_overflow),
    .out_mem_addr     (out_mem_addr),
    .out_mem_read     (out_mem_read),
    .out_mem_write    (out_mem_write),
    .out_mem_is_byte  (out_mem_is_byte),
    .out_store_data   (out_store_data),
    .out_branch_taken (out_branch_taken),
    .out_link_request (out_link_request)
  );

  always #5 clk = ~clk;

  function automatic res_t execute_expect(op_t op);
    logic [31:0] simm;
    logic [31:0] zimm;
    logic [31:0] sum;
    logic [7:0]  lbyte;
    res_t        r;
    simm  = {{16{op.immediate[15]}}, op.immediate};
    zimm  = {16'h0000, op.immediate};
    sum   = op.rs_value + simm;
    lbyte = op.load_data[7:0];
    r     = '0;
    case (op.mode)
      MODE_ADDI: begin
        if (op.rs_value[31] == simm[31] && sum[31] != op.rs_value[31]) begin
          r.overflow = 1'b1;
        end else begin
          r.reg_result = sum;
          r.reg_write  = 1'b1;
        end
      end
      MODE_ADDIU: begin
        r.reg_result = sum;
        r.reg_write  = 1'b1;
      end
      MODE_ANDI: begin
        r.reg_result = op.rs_value & zimm;
        r.reg_write  = 1'b1;
      end
      MODE_ORI: begin
        r.reg_result = op.rs_value | zimm;
        r.reg_write  = 1'b1;
      end
      MODE_XORI: begin
        r.reg_result = op.rs_value ^ zimm;
        r.reg_write  = 1'b1;
      end
      MODE_SLTI: begin
        r.reg_result = {31'b0, $signed(op.rs_value) < $signed(simm)};
        r.reg_write  = 1'b1;
      end
      MODE_SLTIU: begin
        r.reg_result = {31'b0, op.rs_value < simm};
        r.reg_write  = 1'b1;
      end
      MODE_LW, MODE_LB, MODE_LBU: begin
        r.reg_write   = 1'b1;
        r.mem_addr    = sum;
        r.mem_read    = 1'b1;
        r.mem_is_byte = (op.mode != MODE_LW);
        if (op.mode == MODE_LW) begin
          r.reg_result = op.load_data;
        end else if (op.mode == MODE_LB) begin
          r.reg_result = {{24{lbyte[7]}}, lbyte};
        end else begin
          r.reg_result = {24'h000000, lbyte};
        end
      end
      MODE_SW: begin
        r.mem_addr   = sum;
        r.mem_write  = 1'b1;
        r.store_data = op.rt_value;
      end
      MODE_SB: begin
        r.mem_addr    = sum;
        r.mem_write   = 1'b1;
        r.mem_is_byte = 1'b1;
        r.store_data  = {24'h000000, op.rt_value[7:0]};
      end
      MODE_BEQ:  r.branch_taken = (op.rs_value == op.rt_value);
      MODE_BNE:  r.branch_taken = (op.rs_value != op.rt_value);
      MODE_BGEZ: r.branch_taken = !op.rs_value[31];
      MODE_BGTZ: r.branch_taken = !op.rs_value[31] && op.rs_value != 32'h0;
      MODE_BLEZ: r.branch_taken = op.rs_value[31] || op.rs_value == 32'h0;
      MODE_BLTZ: r.branch_taken = op.rs_value[31];
      MODE_BGEZAL: begin
        r.branch_taken = !op.rs_value[31];
        r.link_request = 1'b1;
      end
      MODE_BLTZAL: begin
        r.branch_taken = op.rs_value[31];
        r.link_request = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h7fff;
      3: return 16'h8000;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_op(logic [4:0] m, logic [31:0] rs, logic [31:0] rt, logic [15:0] imm,
                        logic [31:0] ld);
    op_t op;
    op.mode      = m;
    op.rs_value  = rs;
    op.rt_value  = rt;
    op.immediate = imm;
    op.load_data = ld;
    pending_ops.push_back(op);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
      fails++;
    end
  endtask

  // idle rates by phase of the run
  always_comb begin
    if (issued < total_ops / 3) begin
      send_idle_pct = 15;
      recv_idle_pct = 76;
    end else if (issued < 2 * total_ops / 3) begin
      send_idle_pct = 76;
      recv_idle_pct = 15;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_op   <= pending_ops.pop_front();
        in_valid <= 1'b1;
        issued   <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk) begin
    res_t exp_res;
    in_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        exec_expected.push_back(execute_expect(cur_op));
        accepted <= accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (exec_expected.size() == 0) begin
          $error("result transaction with no instruction outstanding");
          fails++;
        end else begin
          exp_res = exec_expected.pop_front();
          check_field("reg_result", exp_res.reg_result, out_reg_result);
          check_field("reg_write", 32'(exp_res.reg_write), 32'(out_reg_write));
          check_field("overflow", 32'(exp_res.overflow), 32'(out_overflow));
          check_field("mem_addr", exp_res.mem_addr, out_mem_addr);
          check_field("mem_read", 32'(exp_res.mem_read), 32'(out_mem_read));
          check_field("mem_write", 32'(exp_res.mem_write), 32'(out_mem_write));
          check_field("mem_is_byte", 32'(exp_res.mem_is_byte), 32'(out_mem_is_byte));
          check_field("store_data", exp_res.store_data, out_store_data);
          check_field("branch_taken", 32'(exp_res.branch_taken), 32'(out_branch_taken));
          check_field("link_request", 32'(exp_res.link_request), 32'(out_link_request));
        end
      end
    end
  end

  initial begin
    logic [4:0]  m;
    logic [31:0] rs;
    logic [31:0] rt;
    // directed corners
    add_op(MODE_ADDI, 32'h7fff_ffff, 32'h0, 16'h0001, 32'h0);
    add_op(MODE_ADDI, 32'h8000_0000, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_ADDI, 32'h0000_0010, 32'h0, 16'hfff0, 32'h0);
    add_op(MODE_ADDIU, 32'h7fff_ffff, 32'h0, 16'h0001, 32'h0);
    add_op(MODE_ADDIU, 32'hffff_ffff, 32'h0, 16'h8000, 32'h0);
    add_op(MODE_ANDI, 32'hffff_ffff, 32'h0, 16'h8001, 32'h0);
    add_op(MODE_ORI, 32'h0000_0000, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_XORI, 32'haaaa_aaaa, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_SLTI, 32'h0000_0000, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_SLTI, 32'h8000_0000, 32'h0, 16'h7fff, 32'h0);
    add_op(MODE_SLTIU, 32'h0000_0005, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_SLTIU, 32'hffff_ffff, 32'h0, 16'hffff, 32'h0);
    add_op(MODE_LW, 32'h0000_0004, 32'h0, 16'hfffc, 32'hdead_beef);
    add_op(MODE_LB, 32'hffff_fff0, 32'h0, 16'h0010, 32'h1234_5680);
    add_op(MODE_LBU, 32'h1000_0000, 32'h0, 16'h7fff, 32'hffff_ff80);
    add_op(MODE_SW, 32'h8000_0000, 32'hffff_ffff, 16'h8000, 32'h0);
    add_op(MODE_SB, 32'h0000_0000, 32'hffff_ffa5, 16'h0003, 32'h0);
    add_op(MODE_BEQ, 32'hffff_ffff, 32'hffff_ffff, 16'h0, 32'h0);
    add_op(MODE_BNE, 32'h0000_0000, 32'h0000_0000, 16'h0, 32'h0);
    add_op(MODE_BGEZ, 32'h0000_0000, 32'h0, 16'h0, 32'h0);
    add_op(MODE_BGTZ, 32'h0000_0000, 32'h0, 16'h0, 32'h0);
    add_op(MODE_BLEZ, 32'h0000_0000, 32'h0, 16'h0, 32'h0);
    add_op(MODE_BLTZ, 32'h8000_0000, 32'h0, 16'h0, 32'h0);
    add_op(MODE_BGEZAL, 32'h8000_0000, 32'h0, 16'h0, 32'h0);
    add_op(MODE_BLTZAL, 32'h7fff_ffff, 32'h0, 16'h0, 32'h0);
    add_op(MODE_UNUSED_LAST, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
    // random instructions, mostly defined modes
    repeat (RANDOM_OPS) begin
      if ($urandom_range(9) == 0) begin
        m = 5'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST));
      end else begin
        m = 5'($urandom_range(MODE_BLTZAL, MODE_ADDI));
      end
      rs = pick_word();
      rt = ($urandom_range(3) == 0) ? rs : pick_word();
      add_op(m, rs, rt, pick_imm(), pick_word());
    end
    total_ops = pending_ops.size();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted != total_ops || exec_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("immediate_alu_branch_execute_top verification clean");
    end else begin
      $display("immediate_alu_branch_execute_top verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("immediate_alu_branch_execute_top verification failed");
    $finish;
  end

endmodule

`default_nettype wire
